// File: rtl/core/energy_gate_voice_activity_macros.svh
// Assertion macros for the voice activity gate.
// Both expect a signal named clk in the scope of use; EGVA_ASSERT also expects rst.
`ifndef ENERGY_GATE_VOICE_ACTIVITY_MACROS_SVH
`define ENERGY_GATE_VOICE_ACTIVITY_MACROS_SVH
`ifndef ASSERT_OFF
`define EGVA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define EGVA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EGVA_ASSERT(lbl, prop, msg)
`define EGVA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/core/egva_pkg.sv
`timescale 1ns / 1ps
package egva_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int MAX_PACKET_DEF   = 2560;

  // config register widths
  localparam int PLEN_W  = 12;
  localparam int PRE_W   = 14;
  localparam int HANG_W  = 18;
  localparam int GATE_W  = 15;
  localparam int CFG_W   = 18;
  localparam int ADDR_W  = 3;

  // result field widths
  localparam int QUIET_W = 18;
  localparam int PKT_W   = 12;
  localparam int OUT_W   = 32;

  localparam logic [ADDR_W-1:0] REG_PACKET_LEN   = 3'd0;
  localparam logic [ADDR_W-1:0] REG_PREROLL_CAP  = 3'd1;
  localparam logic [ADDR_W-1:0] REG_HANGOVER_LEN = 3'd2;
  localparam logic [ADDR_W-1:0] REG_GATE_LEVEL   = 3'd3;
  localparam logic [ADDR_W-1:0] REG_GATE_ENABLE  = 3'd4;

  localparam logic [PLEN_W-1:0] PACKET_LEN_RST   = 12'd320;
  localparam logic [PRE_W-1:0]  PREROLL_CAP_RST  = 14'd4800;
  localparam logic [HANG_W-1:0] HANGOVER_LEN_RST = 18'd12800;
  localparam logic [GATE_W-1:0] GATE_LEVEL_RST   = 15'd328;

  typedef struct packed {
    logic [PLEN_W-1:0] packet_len;
    logic [PRE_W-1:0]  preroll_cap;
    logic [HANG_W-1:0] hangover_len;
    logic [GATE_W-1:0] gate_level;
    logic              gate_enable;
  } cfg_t;

  typedef struct packed {
    logic              voiced;
    logic              fwd;
    logic              opened;
    logic              closed;
    logic [PRE_W-1:0]  pre_fwd;
    logic [PKT_W-1:0]  pkt;
    logic              done;
  } result_t;

  typedef enum logic [2:0] {
    MAC_HOLD,
    MAC_SQ_LOAD,
    MAC_SQ_STEP,
    MAC_GG_LOAD,
    MAC_NG_LOAD,
    MAC_PR_STEP,
    MAC_CLEAR
  } mac_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_CHK,
    ST_GG,
    ST_NGL,
    ST_NG,
    ST_EVAL,
    ST_UPD
  } state_t;

endpackage

// File: rtl/core/egva_serial_mac.sv
`timescale 1ns / 1ps
// Shift-add multiplier, one multiplier bit per cycle. Squares each sample
// into the packet energy, and at packet end forms n * gate_level^2 in prod.
module egva_serial_mac import egva_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int MAX_PACKET   = MAX_PACKET_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mac_op_t                        cmd,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic [GATE_W-1:0]              gate_level,
  input  logic [$clog2(MAX_PACKET+1)-1:0] n,
  output logic [((2*SAMPLE_WIDTH-1) > 2*GATE_W ? 2*SAMPLE_WIDTH-1 : 2*GATE_W)
                + $clog2(MAX_PACKET+1)-1:0] energy,
  output logic [((2*SAMPLE_WIDTH-1) > 2*GATE_W ? 2*SAMPLE_WIDTH-1 : 2*GATE_W)
                + $clog2(MAX_PACKET+1)-1:0] prod,
  output logic                           last
);

  localparam int CNT_W = $clog2(MAX_PACKET + 1);
  localparam int SQ_W  = (2*SAMPLE_WIDTH-1) > 2*GATE_W ? 2*SAMPLE_WIDTH-1 : 2*GATE_W;
  localparam int ACC_W = SQ_W + CNT_W;
  localparam int MP_A  = SAMPLE_WIDTH > GATE_W ? SAMPLE_WIDTH : GATE_W;
  localparam int MP_W  = MP_A > CNT_W ? MP_A : CNT_W;
  localparam int CT_W  = $clog2(MP_W + 1);

  logic [ACC_W-1:0]        mcand;
  logic [MP_W-1:0]         mplier;
  logic [CT_W-1:0]         cnt;
  logic [SAMPLE_WIDTH-1:0] raw;
  logic [SAMPLE_WIDTH-1:0] mag;

  assign raw  = sample;
  assign mag  = raw[SAMPLE_WIDTH-1] ? (~raw + 1'b1) : raw;
  assign last = (cnt == CT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      energy <= '0;
      prod   <= '0;
      cnt    <= '0;
    end else begin
      unique case (cmd)
        MAC_SQ_LOAD: begin
          mcand  <= ACC_W'(mag);
          mplier <= MP_W'(mag);
          cnt    <= CT_W'(SAMPLE_WIDTH);
        end
        MAC_GG_LOAD: begin
          mcand  <= ACC_W'(gate_level);
          mplier <= MP_W'(gate_level);
          cnt    <= CT_W'(GATE_W);
          prod   <= '0;
        end
        MAC_NG_LOAD: begin
          // prod holds gate_level^2 here
          mcand  <= prod;
          mplier <= MP_W'(n);
          cnt    <= CT_W'(CNT_W);
          prod   <= '0;
        end
        MAC_SQ_STEP, MAC_PR_STEP: begin
          if (mplier[0]) begin
            if (cmd == MAC_SQ_STEP) energy <= energy + mcand;
            else                    prod   <= prod + mcand;
          end
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt - 1'b1;
        end
        MAC_CLEAR: begin
          energy <= '0;
          prod   <= '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/core/egva_segment.sv
`timescale 1ns / 1ps
// Segment tracker: pre-roll count while idle, quiet count with hangover
// while a segment is open. Updates once per evaluated packet.
module egva_segment import egva_pkg::*; #(
  parameter int MAX_PACKET = MAX_PACKET_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            upd,
  input  logic                            voiced,
  input  logic                            eos,
  input  logic [$clog2(MAX_PACKET+1)-1:0] n,
  input  cfg_t                            cfg,
  output result_t                         res
);

  logic               seg_active, seg_next;
  logic [QUIET_W-1:0] quiet_count, quiet_next;
  logic [PRE_W-1:0]   preroll_count, preroll_next;
  logic [QUIET_W:0]   qsum;
  logic [PRE_W:0]     psum;

  assign qsum = {1'b0, quiet_count} + (QUIET_W+1)'(n);
  assign psum = {1'b0, preroll_count} + (PRE_W+1)'(n);

  always_comb begin
    seg_next     = seg_active;
    quiet_next   = quiet_count;
    preroll_next = preroll_count;
    res          = '0;
    res.voiced   = voiced;
    res.pkt      = PKT_W'(n);
    res.done     = eos;

    if (!seg_active && !voiced) begin
      preroll_next = (psum > {1'b0, cfg.preroll_cap}) ? cfg.preroll_cap : psum[PRE_W-1:0];
    end else begin
      res.fwd = 1'b1;
      if (!seg_active) begin
        seg_next     = 1'b1;
        res.opened   = 1'b1;
        res.pre_fwd  = preroll_count;
        preroll_next = '0;
      end
      if (voiced) quiet_next = '0;
      else        quiet_next = qsum[QUIET_W] ? '1 : qsum[QUIET_W-1:0];
      if (cfg.gate_enable && (quiet_next >= cfg.hangover_len)) begin
        res.closed = 1'b1;
        seg_next   = 1'b0;
        quiet_next = '0;
      end
    end

    // end of stream closes any open segment and clears everything
    if (eos) begin
      if (seg_next) res.closed = 1'b1;
      seg_next     = 1'b0;
      quiet_next   = '0;
      preroll_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_active    <= 1'b0;
      quiet_count   <= '0;
      preroll_count <= '0;
    end else if (upd) begin
      seg_active    <= seg_next;
      quiet_count   <= quiet_next;
      preroll_count <= preroll_next;
    end
  end

endmodule

// File: rtl/core/energy_gate_voice_activity.sv
`timescale 1ns / 1ps
// Channel   Dir  Content (low bit up)
// s_axis    in   tdata: sample; tlast: end_of_stream
// m_axis    out  tdata: voiced, forwarded, segment_open, segment_close,
//                       preroll_forward[14], packet_samples[12], zero pad;
//                tlast: stream_done
// cfg       in   cfg_we, cfg_addr (register index), cfg_wdata
//
// A sample is squared by the serial squarer, which retires one bit
// of the magnitude per cycle. The sample that ends a packet also forms
// n*gate_level^2 on the same shift-add unit.
// rst (synchronous) clears the control state, counters and accumulators and loads register defaults.
// A sample is taken only in idle; the update step waits while the output
// register still holds an untaken result.
module energy_gate_voice_activity import egva_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int MAX_PACKET   = MAX_PACKET_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,  // sample
  input  logic                                   s_axis_tlast,  // end_of_stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // voiced, forwarded, segment_open, segment_close, preroll_forward,
  // packet_samples
  output logic [OUT_W-1:0]                       m_axis_tdata,
  output logic                                   m_axis_tlast,  // stream_done
  input  logic                                   cfg_we,
  input  logic [ADDR_W-1:0]                      cfg_addr,
  input  logic [CFG_W-1:0]                       cfg_wdata
);

  `include "energy_gate_voice_activity_macros.svh"

  localparam int CNT_W = $clog2(MAX_PACKET + 1);
  localparam int SQ_W  = (2*SAMPLE_WIDTH-1) > 2*GATE_W ? 2*SAMPLE_WIDTH-1 : 2*GATE_W;
  localparam int ACC_W = SQ_W + CNT_W;

  cfg_t             cfg;
  state_t           state, state_next;
  mac_op_t          mac_cmd;
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] len_eff;
  logic             eos_q;
  logic             voiced_q;
  logic             voiced_next;
  logic [ACC_W-1:0] energy;
  logic [ACC_W-1:0] prod;
  logic             mac_last;
  logic             accept;
  logic             eval_load;
  logic             upd;
  result_t          seg_res;
  result_t          out_q;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.packet_len   <= PACKET_LEN_RST;
      cfg.preroll_cap  <= PREROLL_CAP_RST;
      cfg.hangover_len <= HANGOVER_LEN_RST;
      cfg.gate_level   <= GATE_LEVEL_RST;
      cfg.gate_enable  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PACKET_LEN:   cfg.packet_len   <= cfg_wdata[PLEN_W-1:0];
        REG_PREROLL_CAP:  cfg.preroll_cap  <= cfg_wdata[PRE_W-1:0];
        REG_HANGOVER_LEN: cfg.hangover_len <= cfg_wdata[HANG_W-1:0];
        REG_GATE_LEVEL:   cfg.gate_level   <= cfg_wdata[GATE_W-1:0];
        REG_GATE_ENABLE:  cfg.gate_enable  <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // zero length acts as one, lengths above the maximum are clamped
  always_comb begin
    if (cfg.packet_len == '0)                     len_eff = CNT_W'(1);
    else if (32'(cfg.packet_len) > MAX_PACKET)    len_eff = CNT_W'(MAX_PACKET);
    else                                          len_eff = CNT_W'(cfg.packet_len);
  end

  assign voiced_next = !cfg.gate_enable || (energy > prod);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next    = state;
    mac_cmd       = MAC_HOLD;
    s_axis_tready = 1'b0;
    eval_load     = 1'b0;
    upd           = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          mac_cmd    = MAC_SQ_LOAD;
          state_next = ST_SQ;
        end
      end
      ST_SQ: begin
        mac_cmd = MAC_SQ_STEP;
        if (mac_last) state_next = ST_CHK;
      end
      ST_CHK: begin
        if ((fill_count >= len_eff) || eos_q) begin
          mac_cmd    = MAC_GG_LOAD;
          state_next = ST_GG;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_GG: begin
        mac_cmd = MAC_PR_STEP;
        if (mac_last) state_next = ST_NGL;
      end
      ST_NGL: begin
        mac_cmd    = MAC_NG_LOAD;
        state_next = ST_NG;
      end
      ST_NG: begin
        mac_cmd = MAC_PR_STEP;
        if (mac_last) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        eval_load  = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          upd        = 1'b1;
          mac_cmd    = MAC_CLEAR;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      eos_q      <= 1'b0;
    end else if (accept) begin
      fill_count <= fill_count + 1'b1;
      eos_q      <= s_axis_tlast;
    end else if (upd) begin
      fill_count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_load) voiced_q <= voiced_next;
  end

  egva_serial_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .MAX_PACKET   (MAX_PACKET)
  ) u_mac (
    .clk        (clk),
    .rst        (rst),
    .cmd        (mac_cmd),
    .sample     (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .gate_level (cfg.gate_level),
    .n          (fill_count),
    .energy     (energy),
    .prod       (prod),
    .last       (mac_last)
  );

  egva_segment #(
    .MAX_PACKET (MAX_PACKET)
  ) u_segment (
    .clk    (clk),
    .rst    (rst),
    .upd    (upd),
    .voiced (voiced_q),
    .eos    (eos_q),
    .n      (fill_count),
    .cfg    (cfg),
    .res    (seg_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (upd) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) out_q <= seg_res;
  end

  assign m_axis_tdata = OUT_W'({out_q.pkt, out_q.pre_fwd, out_q.closed,
                                out_q.opened, out_q.fwd, out_q.voiced});
  assign m_axis_tlast = out_q.done;

  `EGVA_ASSERT(a_valid_from_update,
               $rose(m_axis_tvalid) |-> $past(state) == ST_UPD,
               "result without update step")
  `EGVA_ASSERT(a_open_is_voiced,
               m_axis_tvalid && out_q.opened |-> out_q.voiced && out_q.fwd,
               "segment opened on unvoiced packet")
  `EGVA_ASSERT(a_preroll_only_on_open,
               m_axis_tvalid && !out_q.opened |-> out_q.pre_fwd == '0,
               "pre-roll forwarded without open")
  `EGVA_ASSERT_ALWAYS(a_fill_bounded,
                      rst || (fill_count <= CNT_W'(MAX_PACKET)),
                      "packet fill past maximum")

endmodule
